// File: hdl/izns_pkg.sv
package izns_pkg;

    // Q16.16 word and the limits that every step saturates to.
    localparam int Q_W    = 32;
    localparam int FRAC_W = 16;
    localparam int SUM_W  = Q_W + 3;
    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    // Configuration register indexes.
    localparam int CFG_IDX_W = 4;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_GAIN_K       = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_REST_V       = t_cfg_idx'(1);
    localparam t_cfg_idx CFG_THRESH_V     = t_cfg_idx'(2);
    localparam t_cfg_idx CFG_PEAK_V       = t_cfg_idx'(3);
    localparam t_cfg_idx CFG_REC_RATE     = t_cfg_idx'(4);
    localparam t_cfg_idx CFG_REC_SENS     = t_cfg_idx'(5);
    localparam t_cfg_idx CFG_RESET_V      = t_cfg_idx'(6);
    localparam t_cfg_idx CFG_REC_JUMP     = t_cfg_idx'(7);

    // Register defaults after reset.
    localparam logic signed [Q_W-1:0] RST_GAIN_K   = 32'sd45875;
    localparam logic signed [Q_W-1:0] RST_REST_V   = -32'sd3932160;
    localparam logic signed [Q_W-1:0] RST_THRESH_V = -32'sd2621440;
    localparam logic signed [Q_W-1:0] RST_PEAK_V   = 32'sd2293760;
    localparam logic signed [Q_W-1:0] RST_REC_RATE = 32'sd1966;
    localparam logic signed [Q_W-1:0] RST_REC_SENS = -32'sd131072;
    localparam logic signed [Q_W-1:0] RST_RESET_V  = -32'sd3276800;
    localparam logic signed [Q_W-1:0] RST_REC_JUMP = 32'sd6553600;

    // Default 1/C in Q16.16.
    localparam int INV_CAPACITANCE_DEF = 655;

    // Sequencer steps.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF1,
        ST_DIFF2,
        ST_MULQ,
        ST_MULK,
        ST_MULA,
        ST_MULC,
        ST_NV,
        ST_FIN
    } t_state;

    // Saturate a wide sum back to the Q16.16 range.
    function automatic logic signed [Q_W-1:0] sat_sum(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(Q_MAX);
        lo = SUM_W'(Q_MIN);
        if (s > hi) begin
            return Q_MAX;
        end else if (s < lo) begin
            return Q_MIN;
        end
        return s[Q_W-1:0];
    endfunction

    // Q16.16 product: floor shift of the exact product, then saturate.
    function automatic logic signed [Q_W-1:0] mul_q(input logic signed [Q_W-1:0] a,
                                                    input logic signed [Q_W-1:0] b);
        logic signed [2*Q_W-1:0]        p;
        logic signed [2*Q_W-FRAC_W-1:0] s;
        p = a * b;
        s = p[2*Q_W-1:FRAC_W];
        if (s > (2*Q_W-FRAC_W)'(Q_MAX)) begin
            return Q_MAX;
        end else if (s < (2*Q_W-FRAC_W)'(Q_MIN)) begin
            return Q_MIN;
        end
        return s[Q_W-1:0];
    endfunction

endpackage

// File: hdl/izns_if.sv
// Channel carrying one drive current item.
interface izns_drive_if;
    logic                              valid;
    logic                              ready;
    logic signed [izns_pkg::Q_W-1:0]   drive_current;

    modport source (output valid, output drive_current, input ready);
    modport sink (input valid, input drive_current, output ready);
endinterface

// Channel carrying one neuron result item.
interface izns_result_if;
    logic                              valid;
    logic                              ready;
    logic signed [izns_pkg::Q_W-1:0]   membrane_voltage;
    logic signed [izns_pkg::Q_W-1:0]   recovery_value;
    logic                              spike_flag;

    modport source (output valid, output membrane_voltage, output recovery_value,
                    output spike_flag, input ready);
    modport sink (input valid, input membrane_voltage, input recovery_value,
                  input spike_flag, output ready);
endinterface

// Configuration write channel.
interface izns_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [izns_pkg::CFG_IDX_W-1:0]      reg_index;
    logic [izns_pkg::Q_W-1:0]            reg_data;

    modport source (output valid, output reg_index, output reg_data, input ready);
    modport sink (input valid, input reg_index, input reg_data, output ready);
endinterface

// File: hdl/izhikevich_neuron_step_unit.sv
// One Euler tick of an Izhikevich neuron in signed Q16.16 per drive current item.
// An accepted item is worked through eight sequencer steps on one shared 32x32
// multiplier and one saturating three-input adder; a new item is taken only once
// the block is back in idle after the final step. The multiplier chain runs
// (v-vr)(v-vt), then k, then 1/C, in that order. The result sits in an output
// register, and the next item is accepted while it waits; the final step holds
// until that register is free. Configuration writes are always taken and must be
// made while the block is idle; a write to an unknown index is ignored.
module izhikevich_neuron_step_unit #(
    parameter int INV_CAPACITANCE = izns_pkg::INV_CAPACITANCE_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    izns_drive_if.sink           i_drive,
    izns_result_if.source        o_result,
    izns_cfg_if.sink             i_cfg
);
    import izns_pkg::*;

    localparam logic signed [Q_W-1:0] INV_C_Q = Q_W'(INV_CAPACITANCE);

    t_state r_state, n_state;

    // Configuration registers.
    logic signed [Q_W-1:0] r_k, r_vr, r_vt, r_vpeak, r_a, r_b, r_c, r_d;

    // Neuron state and per-item working registers.
    logic signed [Q_W-1:0] r_v, r_u, r_cur;
    logic signed [Q_W-1:0] r_d1, r_d2, r_m, r_f, r_p, r_s, r_nu, r_nv;

    // Output register.
    logic                  r_out_valid;
    logic signed [Q_W-1:0] r_out_v, r_out_u;
    logic                  r_out_spk;

    // Shared unit operands and results.
    logic signed [Q_W-1:0]   mul_x, mul_y, mul_r;
    logic signed [SUM_W-1:0] add_x, add_y, add_z;
    logic signed [Q_W-1:0]   add_r;
    logic                    in_acc, out_free, spike;

    assign in_acc   = i_drive.valid && i_drive.ready;
    assign out_free = !r_out_valid || o_result.ready;
    assign spike    = (r_nv >= r_vpeak);

    assign i_drive.ready             = (r_state == ST_IDLE);
    assign i_cfg.ready               = 1'b1;
    assign o_result.valid            = r_out_valid;
    assign o_result.membrane_voltage = r_out_v;
    assign o_result.recovery_value   = r_out_u;
    assign o_result.spike_flag       = r_out_spk;

    // Next step of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (in_acc) n_state = ST_DIFF1;
            ST_DIFF1: n_state = ST_DIFF2;
            ST_DIFF2: n_state = ST_MULQ;
            ST_MULQ:  n_state = ST_MULK;
            ST_MULK:  n_state = ST_MULA;
            ST_MULA:  n_state = ST_MULC;
            ST_MULC:  n_state = ST_NV;
            ST_NV:    n_state = ST_FIN;
            ST_FIN:   if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Operand selection for the shared multiplier and adder.
    always_comb begin
        mul_x = '0;
        mul_y = '0;
        add_x = '0;
        add_y = '0;
        add_z = '0;
        case (r_state)
            ST_DIFF1: begin
                add_x = SUM_W'(r_v);
                add_y = -SUM_W'(r_vr);
            end
            ST_DIFF2: begin
                mul_x = r_b;
                mul_y = r_d1;
                add_x = SUM_W'(r_v);
                add_y = -SUM_W'(r_vt);
            end
            ST_MULQ: begin
                mul_x = r_d1;
                mul_y = r_d2;
                add_x = SUM_W'(r_m);
                add_y = -SUM_W'(r_u);
            end
            ST_MULK: begin
                mul_x = r_k;
                mul_y = r_p;
            end
            ST_MULA: begin
                mul_x = r_a;
                mul_y = r_f;
                add_x = SUM_W'(r_p);
                add_y = -SUM_W'(r_u);
                add_z = SUM_W'(r_cur);
            end
            ST_MULC: begin
                mul_x = r_s;
                mul_y = INV_C_Q;
                add_x = SUM_W'(r_u);
                add_y = SUM_W'(r_m);
            end
            ST_NV: begin
                add_x = SUM_W'(r_v);
                add_y = SUM_W'(r_p);
            end
            ST_FIN: begin
                add_x = SUM_W'(r_nu);
                add_y = SUM_W'(r_d);
            end
            default: begin
                mul_x = '0;
            end
        endcase
    end

    assign mul_r = mul_q(mul_x, mul_y);
    assign add_r = sat_sum(add_x + add_y + add_z);

    // Sequencer and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Configuration registers and neuron state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k     <= RST_GAIN_K;
            r_vr    <= RST_REST_V;
            r_vt    <= RST_THRESH_V;
            r_vpeak <= RST_PEAK_V;
            r_a     <= RST_REC_RATE;
            r_b     <= RST_REC_SENS;
            r_c     <= RST_RESET_V;
            r_d     <= RST_REC_JUMP;
            r_v     <= RST_RESET_V;
            r_u     <= RST_REC_JUMP;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.reg_index)
                    CFG_GAIN_K:   r_k     <= i_cfg.reg_data;
                    CFG_REST_V:   r_vr    <= i_cfg.reg_data;
                    CFG_THRESH_V: r_vt    <= i_cfg.reg_data;
                    CFG_PEAK_V:   r_vpeak <= i_cfg.reg_data;
                    CFG_REC_RATE: r_a     <= i_cfg.reg_data;
                    CFG_REC_SENS: r_b     <= i_cfg.reg_data;
                    CFG_RESET_V:  r_c     <= i_cfg.reg_data;
                    CFG_REC_JUMP: r_d     <= i_cfg.reg_data;
                    default: ;
                endcase
            end
            if (r_state == ST_FIN && out_free) begin
                r_v <= spike ? r_c : r_nv;
                r_u <= spike ? add_r : r_nu;
            end
        end
    end

    // Working registers and the result payload.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cur <= i_drive.drive_current;
        end
        case (r_state)
            ST_DIFF1: r_d1 <= add_r;
            ST_DIFF2: begin
                r_d2 <= add_r;
                r_m  <= mul_r;
            end
            ST_MULQ: begin
                r_p <= mul_r;
                r_f <= add_r;
            end
            ST_MULK: r_p <= mul_r;
            ST_MULA: begin
                r_m <= mul_r;
                r_s <= add_r;
            end
            ST_MULC: begin
                r_p  <= mul_r;
                r_nu <= add_r;
            end
            ST_NV: r_nv <= add_r;
            ST_FIN: begin
                if (out_free) begin
                    r_out_v   <= spike ? r_c : r_nv;
                    r_out_u   <= spike ? add_r : r_nu;
                    r_out_spk <= spike;
                end
            end
            default: ;
        endcase
    end

endmodule

// File: hdl/izns_checker.sv
// Port-level checks on the neuron step unit.
module izns_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_v,
    input logic [31:0] i_out_u,
    input logic        i_out_spk
);

    // An accepted item keeps the block busy for the following cycles.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready ##1 !i_in_ready)
        else $error("input accepted again while an item is in work");

    // A fresh result only appears at the end of a busy period.
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared without an item in work");

    // No result is pending right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_v) && $stable(i_out_u) && $stable(i_out_spk)))
        else $error("stalled result changed");

endmodule

bind izhikevich_neuron_step_unit izns_checker u_izns_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_drive.valid),
    .i_in_ready  (i_drive.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_v     (o_result.membrane_voltage),
    .i_out_u     (o_result.recovery_value),
    .i_out_spk   (o_result.spike_flag)
);
